/* hw/rtl/smap_pkg.sv */
// Shared types, codes and constants for the stretch blit pixel mapper.
// No dependencies; imported by every module of the block.
package smap_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_PIX_DEF    = 4;
  localparam int DATA_W         = 32;
  localparam int PIX_CNT_W      = 3;
  localparam int CFG_IDX_W      = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd6;

  // Pixel depth codes
  localparam logic [1:0] DEPTH_8    = 2'd0;
  localparam logic [1:0] DEPTH_16   = 2'd1;
  localparam logic [1:0] DEPTH_32   = 2'd2;
  localparam logic [1:0] DEPTH_NONE = 2'd3;

  typedef struct packed {
    logic take;   // capture the data word
    logic mul;    // form the products and load the dividers
    logic step;   // one divider iteration
    logic emit;   // load the result register and advance the counter
    logic last;   // final pixel of this word
  } smap_cmd_t;

  typedef struct packed {
    logic                 active;   // ready latched and depth gives pixels
    logic [PIX_CNT_W-1:0] pix_cnt;  // pixels in one word at this depth
    logic                 out_free; // result register can take a new pixel
  } smap_sts_t;

  function automatic logic [PIX_CNT_W-1:0] pix_per_word(input logic [1:0] depth);
    logic [PIX_CNT_W-1:0] n;
    case (depth)
      DEPTH_8:  n = 3'd4;
      DEPTH_16: n = 3'd2;
      DEPTH_32: n = 3'd1;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/smap_div.sv */
// Restoring divider, one quotient bit per cycle while step is high, W iterations.
// Expects the high half of the dividend below the divisor. Uses smap_pkg.
module smap_div
  import smap_pkg::*;
#(
  parameter int W = COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           init,
  input  logic           step,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic [W-1:0]   quot
);

  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] lo_r, lo_nxt;
  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         ge;

  always_comb begin
    shifted = {rem_r, lo_r[W-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    if (init) begin
      rem_nxt = dividend[2*W-1:W];
      lo_nxt  = dividend[W-1:0];
    end else if (step) begin
      rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      // quotient bits shift in behind the dividend bits
      lo_nxt  = {lo_r[W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
  end

  assign quot = lo_r;

endmodule

/* hw/rtl/smap_dp.sv */
// Datapath: configuration registers, source counter, multipliers, two dividers
// and the result register. Uses smap_pkg and smap_div.
module smap_dp
  import smap_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  logic [DATA_W-1:0]     in_data_word,
  input  smap_cmd_t             cmd,
  output smap_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_write_enable,
  output logic [COORD_BITS-1:0] out_pix_x,
  output logic [COORD_BITS-1:0] out_pix_y,
  output logic [DATA_W-1:0]     out_color,
  output logic                  out_last
);

  localparam int CW = COORD_BITS;

  logic [CW-1:0] dest_x_r, dest_y_r, dest_w_r, dest_h_r, src_w_r, src_h_r;
  logic [1:0]    depth_r;
  logic          ready_r;
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0] col_inc, row_inc;

  logic [DATA_W-1:0] word_r;
  logic [DATA_W-1:0] color;

  logic [2*CW-1:0] prod_x, prod_y;
  logic [CW-1:0]   quot_x, quot_y, off_x, off_y;
  logic [CW-1:0]   px, py;
  logic [CW:0]     lim_x, lim_y;
  logic            in_rect;

  logic              out_valid_r, out_valid_nxt;
  logic              we_r;
  logic [CW-1:0]     pix_x_r, pix_y_r;
  logic [DATA_W-1:0] color_r;
  logic              last_r;

  // Counter: step one pixel, wrap at row end and at image end
  always_comb begin
    col_inc = col_r + 1'b1;
    row_inc = row_r + 1'b1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.emit) begin
      if (col_inc >= src_w_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= src_h_r) ? '0 : row_inc;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r <= '0;
      dest_y_r <= '0;
      dest_w_r <= '0;
      dest_h_r <= '0;
      src_w_r  <= '0;
      src_h_r  <= '0;
      depth_r  <= DEPTH_8;
      ready_r  <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEST_X: dest_x_r <= cfg_wdata;
        REG_DEST_Y: dest_y_r <= cfg_wdata;
        REG_DEST_W: dest_w_r <= cfg_wdata;
        REG_DEST_H: dest_h_r <= cfg_wdata;
        REG_SRC_W: begin
          src_w_r <= cfg_wdata;
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_SRC_H: begin
          src_h_r <= cfg_wdata;
          col_r   <= '0;
          row_r   <= '0;
          ready_r <= (src_w_r != '0) && (cfg_wdata != '0) &&
                     (dest_w_r != '0) && (dest_h_r != '0);
        end
        REG_DEPTH: depth_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Hold the word; drop the pixel just sent from the bottom
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      word_r <= in_data_word;
    end else if (cmd.emit) begin
      case (depth_r)
        DEPTH_8:  word_r <= {8'd0, word_r[DATA_W-1:8]};
        DEPTH_16: word_r <= {16'd0, word_r[DATA_W-1:16]};
        default:  word_r <= word_r;
      endcase
    end
  end

  always_comb begin
    case (depth_r)
      DEPTH_8:  color = {24'd0, word_r[7:0]};
      DEPTH_16: color = {16'd0, word_r[15:0]};
      default:  color = word_r;
    endcase
  end

  assign prod_x = {{CW{1'b0}}, col_r} * {{CW{1'b0}}, dest_w_r};
  assign prod_y = {{CW{1'b0}}, row_r} * {{CW{1'b0}}, dest_h_r};

  smap_div #(.W(CW)) u_div_x (
    .clk      (clk),
    .init     (cmd.mul),
    .step     (cmd.step),
    .dividend (prod_x),
    .divisor  (src_w_r),
    .quot     (quot_x)
  );

  smap_div #(.W(CW)) u_div_y (
    .clk      (clk),
    .init     (cmd.mul),
    .step     (cmd.step),
    .dividend (prod_y),
    .divisor  (src_h_r),
    .quot     (quot_y)
  );

  // A zero source size gives no offset
  always_comb begin
    off_x   = (src_w_r == '0) ? '0 : quot_x;
    off_y   = (src_h_r == '0) ? '0 : quot_y;
    px      = dest_x_r + off_x;
    py      = dest_y_r + off_y;
    lim_x   = {1'b0, dest_x_r} + {1'b0, dest_w_r};
    lim_y   = {1'b0, dest_y_r} + {1'b0, dest_h_r};
    in_rect = ({1'b0, px} < lim_x) && ({1'b0, py} < lim_y);
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      we_r    <= in_rect;
      pix_x_r <= px;
      pix_y_r <= py;
      color_r <= color;
      last_r  <= cmd.last;
    end
  end

  assign sts.active   = ready_r && (depth_r != DEPTH_NONE);
  assign sts.pix_cnt  = pix_per_word(depth_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_pix_x        = pix_x_r;
  assign out_pix_y        = pix_y_r;
  assign out_color        = color_r;
  assign out_last         = last_r;

endmodule

/* hw/rtl/smap_ctrl.sv */
// Controller: sequences each word through multiply, divide and result load,
// one pixel at a time. Uses smap_pkg.
module smap_ctrl
  import smap_pkg::*;
#(
  parameter int COORD_BITS          = COORD_BITS_DEF,
  parameter int MAX_PIXELS_PER_WORD = MAX_PIX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  smap_sts_t sts,
  output smap_cmd_t cmd
);

  localparam int STEP_W = $clog2(COORD_BITS);
  localparam logic [PIX_CNT_W-1:0] MAX_CNT = PIX_CNT_W'(MAX_PIXELS_PER_WORD);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t               state_r;
  logic [STEP_W-1:0]    step_r;
  logic [PIX_CNT_W-1:0] left_r;
  logic [PIX_CNT_W-1:0] cnt_clip;
  logic                 in_xfer;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cnt_clip = (sts.pix_cnt > MAX_CNT) ? MAX_CNT : sts.pix_cnt;

  always_comb begin
    cmd      = '0;
    cmd.take = in_xfer && sts.active;
    cmd.mul  = (state_r == S_MUL);
    cmd.step = (state_r == S_DIV);
    cmd.emit = (state_r == S_OUT) && sts.out_free;
    cmd.last = (left_r == PIX_CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      left_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          // a word that yields no pixels is simply dropped
          if (in_xfer && sts.active) begin
            left_r  <= cnt_clip;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          step_r  <= STEP_W'(COORD_BITS - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (step_r == '0) begin
            state_r <= S_OUT;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_OUT: begin
          if (sts.out_free) begin
            left_r  <= left_r - 1'b1;
            state_r <= cmd.last ? S_IDLE : S_MUL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/stretch_blit_pixel_mapper_top.sv */
// Stretch blit pixel mapper: nearest-neighbour scaling of packed pixel words.
// Each pixel goes through the product, COORD_BITS divider steps and the load into
// the result register, which waits while a held result is stalled. A word is
// accepted first, then its pixels follow one at a time; the input stalls until
// the last is loaded. Words that give no pixels are dropped. Synchronous reset
// clears the config registers, source counter and ready flag; nothing comes out.
module stretch_blit_pixel_mapper_top
  import smap_pkg::*;
#(
  parameter int COORD_BITS          = COORD_BITS_DEF,
  parameter int MAX_PIXELS_PER_WORD = MAX_PIX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_data_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_write_enable,
  output logic [COORD_BITS-1:0] out_pix_x,
  output logic [COORD_BITS-1:0] out_pix_y,
  output logic [DATA_W-1:0]     out_color,
  output logic                  out_last
);

  smap_cmd_t cmd;
  smap_sts_t sts;

  assign cfg_ready = 1'b1;

  smap_ctrl #(
    .COORD_BITS          (COORD_BITS),
    .MAX_PIXELS_PER_WORD (MAX_PIXELS_PER_WORD)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  smap_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_data_word     (in_data_word),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_pix_x        (out_pix_x),
    .out_pix_y        (out_pix_y),
    .out_color        (out_color),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten while held");

  // a word that yields no pixels leaves the block free
  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !sts.active) |=> !in_stall)
    else $error("dropped word left the block busy");

  // the last pixel of a word frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (!in_stall && out_valid && out_last))
    else $error("final pixel did not end the word");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

/* tb/tb_stretch_blit_pixel_mapper_top.sv */
// Self-checking testbench for stretch_blit_pixel_mapper_top: directed and random words,
// with the expected destination pixels worked out alongside and compared per transfer.
// Depends on smap_pkg and the block's RTL only.
module tb_stretch_blit_pixel_mapper_top;
  import smap_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int SETTLE = 100;
  localparam int RANDOM_WORDS = 150;

  typedef struct packed {
    logic          we;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [DATA_W-1:0] color;
    logic          last;
  } pixel_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CB-1:0]        cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_data_word;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_write_enable;
  logic [CB-1:0]        out_pix_x;
  logic [CB-1:0]        out_pix_y;
  logic [DATA_W-1:0]    out_color;
  logic                 out_last;

  // Shadow of the block's registers and source counter
  logic [CB-1:0] r_dest_x, r_dest_y, r_dest_w, r_dest_h, r_src_w, r_src_h;
  logic [1:0]    r_depth;
  logic [CB-1:0] col, row;
  bit            frame_ready;

  pixel_t pixel_q[$];
  int     errors;
  bit     idle_on;
  int     mapped_words;

  stretch_blit_pixel_mapper_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_word     (in_data_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_pix_x        (out_pix_x),
    .out_pix_y        (out_pix_y),
    .out_color        (out_color),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL stretch_blit_pixel_mapper_top");
    $finish;
  end

  function automatic logic [CB-1:0] stretch_offset(logic [CB-1:0] idx, logic [CB-1:0] dsz,
                                                   logic [CB-1:0] ssz);
    logic [2*CB-1:0] prod;
    if (ssz == '0) return '0;
    prod = {{CB{1'b0}}, idx} * {{CB{1'b0}}, dsz};
    return CB'(prod / {{CB{1'b0}}, ssz});
  endfunction

  function automatic void step_counter();
    col = col + 1'b1;
    if (col >= r_src_w) begin
      col = '0;
      row = row + 1'b1;
      if (row >= r_src_h) row = '0;
    end
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] addr, logic [CB-1:0] data);
    case (addr)
      REG_DEST_X: r_dest_x = data;
      REG_DEST_Y: r_dest_y = data;
      REG_DEST_W: r_dest_w = data;
      REG_DEST_H: r_dest_h = data;
      REG_SRC_W: begin
        r_src_w = data;
        col = '0;
        row = '0;
      end
      REG_SRC_H: begin
        r_src_h = data;
        col = '0;
        row = '0;
        frame_ready = (r_src_w != '0) && (data != '0) && (r_dest_w != '0) && (r_dest_h != '0);
      end
      REG_DEPTH: r_depth = data[1:0];
      default: ;
    endcase
  endfunction

  // Unpack one word into destination pixels and queue them
  function automatic void map_word(logic [DATA_W-1:0] word);
    int n;
    int bits;
    logic [DATA_W-1:0] mask;
    logic [CB:0] x_end, y_end;
    pixel_t p;
    if (!frame_ready) return;
    case (r_depth)
      DEPTH_8: begin
        n = 4; bits = 8; mask = 32'hFF;
      end
      DEPTH_16: begin
        n = 2; bits = 16; mask = 32'hFFFF;
      end
      DEPTH_32: begin
        n = 1; bits = 0; mask = 32'hFFFF_FFFF;
      end
      default: return;
    endcase
    if (n > MAX_PIX_DEF) n = MAX_PIX_DEF;
    // the rectangle edge is taken without wrapping
    x_end = {1'b0, r_dest_x} + {1'b0, r_dest_w};
    y_end = {1'b0, r_dest_y} + {1'b0, r_dest_h};
    for (int i = 0; i < n; i++) begin
      p.color = (word >> (i * bits)) & mask;
      p.x     = r_dest_x + stretch_offset(col, r_dest_w, r_src_w);
      p.y     = r_dest_y + stretch_offset(row, r_dest_h, r_src_h);
      p.we    = ({1'b0, p.x} < x_end) && ({1'b0, p.y} < y_end);
      p.last  = (i == n - 1);
      pixel_q.push_back(p);
      step_counter();
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel transfer x=%h y=%h", out_pix_x, out_pix_y);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (out_write_enable !== e.we) begin
          $error("write_enable exp %h got %h", e.we, out_write_enable);
          errors++;
        end
        if (out_pix_x !== e.x) begin
          $error("pix_x exp %h got %h", e.x, out_pix_x);
          errors++;
        end
        if (out_pix_y !== e.y) begin
          $error("pix_y exp %h got %h", e.y, out_pix_y);
          errors++;
        end
        if (out_color !== e.color) begin
          $error("color exp %h got %h", e.color, out_color);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %h got %h", e.last, out_last);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_word(logic [DATA_W-1:0] word);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_word = word;
    do @(posedge clk); while (in_stall);
    if (frame_ready && r_depth != DEPTH_NONE) mapped_words++;
    map_word(word);
  endtask

  // Drop valid at the negedge following the last transfer, then let the block drain
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] addr, logic [CB-1:0] data);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(addr, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_frame(logic [CB-1:0] dx, logic [CB-1:0] dy, logic [CB-1:0] dw,
                           logic [CB-1:0] dh, logic [CB-1:0] sw, logic [CB-1:0] sh,
                           logic [CB-1:0] depth);
    cfg_write(REG_DEST_X, dx);
    cfg_write(REG_DEST_Y, dy);
    cfg_write(REG_DEST_W, dw);
    cfg_write(REG_DEST_H, dh);
    cfg_write(REG_DEPTH, depth);
    cfg_write(REG_SRC_W, sw);
    cfg_write(REG_SRC_H, sh);
  endtask

  // Before the frame is latched nothing comes out; a spare index is ignored
  task automatic test_not_ready();
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    cfg_write(REG_SPARE, 16'hFFFF);
    send_word(32'h1234_5678);
  endtask

  task automatic test_depths();
    set_frame(16'd10, 16'd20, 16'd8, 16'd6, 16'd4, 16'd3, {14'd0, DEPTH_8});
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0123_4567);
    cfg_write(REG_DEPTH, {14'h3FFF, DEPTH_16});
    send_word(32'hA5A5_5A5A);
    cfg_write(REG_DEPTH, {14'd0, DEPTH_32});
    send_word(32'h89AB_CDEF);
    // depth three: no pixels and the counter holds
    cfg_write(REG_DEPTH, {14'd0, DEPTH_NONE});
    send_word(32'hDEAD_BEEF);
    cfg_write(REG_DEPTH, {14'd0, DEPTH_8});
    send_word(32'h7654_3210);
  endtask

  task automatic test_coord_extremes();
    // points wrap past the coordinate limit yet count as inside
    set_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, {14'd0, DEPTH_8});
    send_word(32'hC3C3_3C3C);
    send_word(32'h5555_AAAA);
    set_frame(16'hFFF0, 16'h0000, 16'hFFFF, 16'h0001, 16'd2, 16'd1, {14'd0, DEPTH_16});
    send_word(32'h0F0F_F0F0);
    send_word(32'hFFFF_0000);
    // shrink: fewer destination columns than source ones
    set_frame(16'd3, 16'd7, 16'd2, 16'd1, 16'd5, 16'd3, {14'd0, DEPTH_8});
    send_word(32'h1111_2222);
    send_word(32'h3333_4444);
  endtask

  task automatic test_zero_source();
    set_frame(16'd100, 16'd200, 16'd7, 16'd5, 16'd3, 16'd2, {14'd0, DEPTH_8});
    send_word(32'hCAFE_F00D);
    // source width cleared after the frame is latched: x offset zero, row steps per pixel
    cfg_write(REG_SRC_W, 16'd0);
    send_word(32'hBEEF_0001);
    send_word(32'h0000_FFFF);
    // zero destination width keeps the pixels out of the rectangle
    cfg_write(REG_DEST_W, 16'd0);
    send_word(32'h8000_0001);
    // relatching with a zero size leaves the frame not ready
    cfg_write(REG_SRC_W, 16'd4);
    cfg_write(REG_SRC_H, 16'd4);
    send_word(32'h7FFF_FFFE);
  endtask

  function automatic logic [CB-1:0] pick_size(bit allow_zero);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0 && allow_zero) return '0;
    if (sel == 1) return 16'hFFFF;
    if (sel < 5) return CB'($urandom_range(1, 65535));
    return CB'($urandom_range(1, 12));
  endfunction

  task automatic test_random_frames();
    logic [1:0] code;
    int words;
    while (mapped_words < RANDOM_WORDS) begin
      // leave the final frames free of idling
      if (mapped_words > RANDOM_WORDS - 40) idle_on = 1'b0;
      code = ($urandom_range(0, 9) == 0) ? DEPTH_NONE : 2'($urandom_range(0, 2));
      set_frame(CB'($urandom), CB'($urandom), pick_size(1'b1), pick_size(1'b1),
                pick_size(1'b1), pick_size(1'b0), {14'($urandom), code});
      case ($urandom_range(0, 7))
        0: cfg_write(REG_SRC_W, pick_size(1'b0));
        1: cfg_write(REG_DEST_W, pick_size(1'b1));
        2: cfg_write(REG_DEST_H, pick_size(1'b1));
        3: cfg_write(REG_SPARE, CB'($urandom));
        default: ;
      endcase
      words = (frame_ready && r_depth != DEPTH_NONE) ? $urandom_range(8, 20) : 2;
      repeat (words) send_word($urandom);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data_word = '0;
    errors       = 0;
    idle_on      = 1'b1;
    mapped_words = 0;
    r_dest_x = '0; r_dest_y = '0; r_dest_w = '0; r_dest_h = '0;
    r_src_w = '0; r_src_h = '0; r_depth = '0;
    col = '0; row = '0; frame_ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_not_ready();
    test_depths();
    test_coord_extremes();
    test_zero_source();
    mapped_words = 0;
    test_random_frames();

    drain();
    if (errors == 0) begin
      $display("PASS stretch_blit_pixel_mapper_top");
    end else begin
      $display("FAIL stretch_blit_pixel_mapper_top");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/smap_pkg.sv
hw/rtl/smap_div.sv
hw/rtl/smap_dp.sv
hw/rtl/smap_ctrl.sv
hw/rtl/stretch_blit_pixel_mapper_top.sv
tb/tb_stretch_blit_pixel_mapper_top.sv
